// ===== src/cpt_pkg.sv =====
// shared types and constants for the coplanarity test block
// used by cpt_mac and coplanarity_test, no dependencies
package cpt_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FIELD_W        = 16;
	localparam int TOL_W          = 52;
	localparam int ACC_W          = 64;
	localparam int APB_DW         = 64;
	localparam int APB_AW         = 4;
	localparam int REG_IDX_W      = APB_AW - 3;

	localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = '0;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_ADD,
		OP_NSUB,
		OP_OFFS,
		OP_DIST
	} mac_op_t;

	typedef struct packed {
		logic    vld;
		mac_op_t op;
		logic [1:0] idx;
	} mac_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_SUB,
		ST_ABS,
		ST_CMP,
		ST_FIN
	} st_t;

endpackage

// ===== src/cpt_mac.sv =====
// shared signed multiplier with registered product and 64-bit accumulator
// depends on cpt_pkg
module cpt_mac import cpt_pkg::*; #(
	parameter int AW = 2 * COORD_BITS_DEF + 3,
	parameter int BW = COORD_BITS_DEF + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mac_ctl_t             ctl,
	input  logic signed [AW-1:0] op_a,
	input  logic signed [BW-1:0] op_b,
	output mac_ctl_t             ctl_o,
	output logic [ACC_W-1:0]     sum
);

	localparam int PW = AW + BW;

	mac_ctl_t             ctl_s1;
	logic signed [PW-1:0] prod_s1;
	logic [ACC_W-1:0]     acc_q;
	logic [ACC_W-1:0]     prod_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		if (ctl_s1.vld) begin
			acc_q <= sum;
		end
	end

	always_comb begin
		prod_x = ACC_W'(prod_s1);
		case (ctl_s1.op)
			OP_LOAD: sum = prod_x;
			OP_NSUB: sum = acc_q - prod_x;
			default: sum = acc_q + prod_x;
		endcase
	end

	assign ctl_o = ctl_s1;

endmodule

// ===== src/coplanarity_test.sv =====
// top level of the point set coplanarity test
// depends on cpt_pkg and cpt_mac
//
// usage:
// points arrive on the slave stream, one request per point: tdata carries
// x, y, z (signed Q8.8), tlast marks the final point of a set. the master
// stream returns one request per set, the coplanar flag in tdata bit 0.
// the tolerance register (52 bits) is written over the APB port at 0x0.
// timing: s_tready is high only while the block is idle. the first two
// points of a set are only stored. the third point forms the normal and
// offset with nine passes through the one shared multiplier. every later
// point takes three multiplies plus subtract, abs and compare. results go
// to an output register, so a new point is taken while a result waits;
// a set end stalls only if the previous result is still not taken.
// reset clears the set state, the tolerance and the output valid.
module coplanarity_test import cpt_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [3*FIELD_W-1:0]  s_tdata,  // coord_x, coord_y, coord_z
	input  logic                  s_tlast,  // last_point
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata   // coplanar, zero fill
);

	localparam int CB = COORD_BITS;
	localparam int BW = CB + 1;
	localparam int NW = 2 * CB + 3;
	localparam int EW = (CB > FIELD_W) ? CB : FIELD_W;
	localparam int STP_W = 4;
	localparam logic [STP_W-1:0] SETUP_LAST = STP_W'(8);
	localparam logic [STP_W-1:0] CHECK_LAST = STP_W'(2);

	st_t                   st_q, st_nx;
	logic [STP_W-1:0]      stp_q;
	logic [1:0]            cnt_q;
	logic                  planar_q, last_q, chk_q;
	logic [TOL_W-1:0]      tol_q;
	logic                  m_vld_q, m_dat_q;

	logic [EW-1:0]         ext_w [3];
	logic signed [CB-1:0]  pin [3];
	logic signed [CB-1:0]  org_q [3];
	logic signed [CB-1:0]  sec_q [3];
	logic signed [CB-1:0]  pt_q [3];
	logic signed [BW-1:0]  da_q [3];
	logic signed [BW-1:0]  db_q [3];
	logic signed [NW-1:0]  nrm_q [3];
	logic [ACC_W-1:0]      off_q, x_q;

	logic                  acc_in, cfg_wr, out_free, fin_load;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic [STP_W-1:0]      last_stp;
	mac_ctl_t              mctl, mctl_o;
	logic signed [NW-1:0]  op_a;
	logic signed [BW-1:0]  op_b;
	logic [ACC_W-1:0]      mac_sum;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = paddr[APB_AW-1:3];
	assign prdata  = (reg_idx == REG_TOLERANCE) ? APB_DW'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_wr && reg_idx == REG_TOLERANCE) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	// coordinate extraction
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ext_w[i] = EW'(s_tdata[i*FIELD_W +: FIELD_W]);
			pin[i]   = $signed(ext_w[i][CB-1:0]);
		end
	end

	assign acc_in   = s_tvalid & s_tready;
	assign out_free = !m_vld_q || m_tready;
	assign last_stp = chk_q ? CHECK_LAST : SETUP_LAST;

	// next state
	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (acc_in) begin
					st_nx = (cnt_q < 2'd2) ? ST_FIN : ST_RUN;
				end
			end
			ST_RUN: begin
				if (stp_q == last_stp) begin
					st_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: st_nx = chk_q ? ST_SUB : ST_FIN;
			ST_SUB:   st_nx = ST_ABS;
			ST_ABS:   st_nx = ST_CMP;
			ST_CMP:   st_nx = ST_FIN;
			ST_FIN: begin
				if (!last_q || out_free) begin
					st_nx = ST_IDLE;
				end
			end
			default:  st_nx = ST_IDLE;
		endcase
	end

	// outputs and operand selection
	always_comb begin
		s_tready = (st_q == ST_IDLE);
		fin_load = (st_q == ST_FIN) && last_q && out_free;
		mctl     = '0;
		mctl.vld = (st_q == ST_RUN);
		op_a     = '0;
		op_b     = '0;
		if (chk_q) begin
			unique case (stp_q)
				4'd0: begin
					op_a = nrm_q[0]; op_b = BW'(pt_q[0]); mctl.op = OP_LOAD;
				end
				4'd1: begin
					op_a = nrm_q[1]; op_b = BW'(pt_q[1]); mctl.op = OP_ADD;
				end
				4'd2: begin
					op_a = nrm_q[2]; op_b = BW'(pt_q[2]); mctl.op = OP_DIST;
				end
				default: mctl.vld = 1'b0;
			endcase
		end else begin
			unique case (stp_q)
				4'd0: begin
					op_a = NW'(da_q[1]); op_b = db_q[2]; mctl.op = OP_LOAD;
				end
				4'd1: begin
					op_a = NW'(da_q[2]); op_b = db_q[1]; mctl.op = OP_NSUB;
					mctl.idx = 2'd0;
				end
				4'd2: begin
					op_a = NW'(da_q[2]); op_b = db_q[0]; mctl.op = OP_LOAD;
				end
				4'd3: begin
					op_a = NW'(da_q[0]); op_b = db_q[2]; mctl.op = OP_NSUB;
					mctl.idx = 2'd1;
				end
				4'd4: begin
					op_a = NW'(da_q[0]); op_b = db_q[1]; mctl.op = OP_LOAD;
				end
				4'd5: begin
					op_a = NW'(da_q[1]); op_b = db_q[0]; mctl.op = OP_NSUB;
					mctl.idx = 2'd2;
				end
				4'd6: begin
					op_a = nrm_q[0]; op_b = BW'(org_q[0]); mctl.op = OP_LOAD;
				end
				4'd7: begin
					op_a = nrm_q[1]; op_b = BW'(org_q[1]); mctl.op = OP_ADD;
				end
				4'd8: begin
					op_a = nrm_q[2]; op_b = BW'(org_q[2]); mctl.op = OP_OFFS;
				end
				default: mctl.vld = 1'b0;
			endcase
		end
	end

	cpt_mac #(
		.AW (NW),
		.BW (BW)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.ctl_o  (mctl_o),
		.sum    (mac_sum)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			stp_q    <= '0;
			cnt_q    <= '0;
			planar_q <= 1'b1;
			last_q   <= 1'b0;
			chk_q    <= 1'b0;
			m_vld_q  <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (acc_in) begin
				last_q <= s_tlast;
				chk_q  <= (cnt_q == 2'd3);
				stp_q  <= '0;
				if (cnt_q != 2'd3) begin
					cnt_q <= cnt_q + 2'd1;
				end
			end else if (st_q == ST_RUN) begin
				stp_q <= stp_q + STP_W'(1);
			end
			if (st_q == ST_CMP && x_q > ACC_W'(tol_q)) begin
				planar_q <= 1'b0;
			end
			if (fin_load) begin
				m_vld_q  <= 1'b1;
				cnt_q    <= '0;
				planar_q <= 1'b1;
			end else if (m_tready) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	// point, normal and distance datapath
	always_ff @(posedge clk) begin
		if (acc_in) begin
			for (int i = 0; i < 3; i++) begin
				case (cnt_q)
					2'd0: org_q[i] <= pin[i];
					2'd1: sec_q[i] <= pin[i];
					2'd2: begin
						da_q[i] <= BW'(sec_q[i]) - BW'(org_q[i]);
						db_q[i] <= BW'(pin[i]) - BW'(org_q[i]);
					end
					default: pt_q[i] <= pin[i];
				endcase
			end
		end
		if (mctl_o.vld) begin
			case (mctl_o.op)
				OP_NSUB: nrm_q[mctl_o.idx] <= $signed(mac_sum[NW-1:0]);
				OP_OFFS: off_q <= mac_sum;
				OP_DIST: x_q   <= mac_sum;
				default: ;
			endcase
		end
		case (st_q)
			ST_SUB: x_q <= x_q - off_q;
			ST_ABS: begin
				if (x_q[ACC_W-1]) begin
					x_q <= '0 - x_q;
				end
			end
			default: ;
		endcase
		if (fin_load) begin
			m_dat_q <= planar_q;
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = {7'b0, m_dat_q};

endmodule
